// ===== hdl/ptt_pkg.sv =====
// Shared types and constants for the push-to-talk trigger arbiter.
package ptt_pkg;

  localparam int CNT_W  = 4;
  localparam int CFG_AW = 5;

  localparam logic [1:0] REQ_LEVEL  = 2'd0;
  localparam logic [1:0] REQ_ESCAPE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] ID_KEY  = 2'd0;
  localparam logic [1:0] ID_BTN1 = 2'd1;
  localparam logic [1:0] ID_BTN2 = 2'd2;

  localparam logic [1:0] KB_HOLD       = 2'd0;
  localparam logic [1:0] KB_TOGGLE     = 2'd1;
  localparam logic [1:0] KB_DOUBLE_TAP = 2'd2;

  localparam logic [1:0] MB_ONE  = 2'd0;
  localparam logic [1:0] MB_BOTH = 2'd1;
  localparam logic [1:0] MB_TWO  = 2'd2;

  localparam logic [2:0] REG_KB_MODE    = 3'd0;
  localparam logic [2:0] REG_MOUSE_BTN  = 3'd1;
  localparam logic [2:0] REG_ENABLES    = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd3;
  localparam logic [2:0] REG_TAP_WINDOW = 3'd4;
  localparam logic [2:0] REG_HOLD_DELAY = 3'd5;

  localparam logic [1:0]  RST_KB_MODE    = KB_HOLD;
  localparam logic [1:0]  RST_MOUSE_BTN  = MB_TWO;
  localparam logic [3:0]  RST_ENABLES    = 4'd0;
  localparam logic [15:0] RST_DEBOUNCE   = 16'd300;
  localparam logic [15:0] RST_TAP_WINDOW = 16'd350;
  localparam logic [15:0] RST_HOLD_DELAY = 16'd1000;

  localparam int EN_KB      = 0;
  localparam int EN_MOUSE   = 1;
  localparam int EN_KB_FS   = 2;
  localparam int EN_MOUSE_FS = 3;

  typedef enum logic [1:0] {
    OWN_NONE  = 2'd0,
    OWN_KEY   = 2'd1,
    OWN_MOUSE = 2'd2
  } owner_t;

  typedef enum logic [1:0] {
    EV_PRESSED   = 2'd0,
    EV_RELEASED  = 2'd1,
    EV_CANCELLED = 2'd2
  } event_t;

  typedef struct packed {
    logic [1:0]  keyboard_mode;
    logic [1:0]  mouse_button;
    logic [3:0]  enable_flags;
    logic [15:0] debounce_ms;
    logic [15:0] double_tap_window_ms;
    logic [15:0] hold_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] input_id;
    logic       down;
    logic       modifiers_match;
    logic       fullscreen;
  } item_t;

  typedef struct packed {
    owner_t           owner;
    logic [2:0]       levels;
    logic             confirm_active;
    logic [CNT_W-1:0] confirm_count;
    logic             hold_active;
    logic             debounce_valid;
    logic             tap_valid;
  } ctl_t;

endpackage

// ===== hdl/ptt_step.sv =====
// Next-state and result logic for one item of the trigger arbiter.
module ptt_step #(
  parameter int CONFIRM_TICKS = 10,
  parameter int TIME_BITS     = 16
) (
  input  ptt_pkg::cfg_t         cfg,
  input  ptt_pkg::item_t        item,
  input  ptt_pkg::ctl_t         ctl,
  input  logic [TIME_BITS-1:0]  deb_e,
  input  logic [TIME_BITS-1:0]  tap_e,
  input  logic [TIME_BITS-1:0]  hold_c,
  output ptt_pkg::ctl_t         ctl_nxt,
  output logic [TIME_BITS-1:0]  deb_e_nxt,
  output logic [TIME_BITS-1:0]  tap_e_nxt,
  output logic [TIME_BITS-1:0]  hold_c_nxt,
  output logic                  emit,
  output ptt_pkg::event_t       ev
);

  localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int CNT_W = ptt_pkg::CNT_W;

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    sat_inc = (&v) ? v : TIME_BITS'(v + 1'b1);
  endfunction

  function automatic logic mouse_held(input logic [2:0] lv, input logic [1:0] sel);
    case (sel)
      ptt_pkg::MB_ONE:  mouse_held = lv[1];
      ptt_pkg::MB_BOTH: mouse_held = lv[1] & lv[2];
      default:          mouse_held = lv[2];
    endcase
  endfunction

  function automatic logic allowed(input logic mouse, input logic fs, input logic dv,
                                   input logic [TIME_BITS-1:0] de, input logic [3:0] en,
                                   input logic [15:0] deb_ms);
    logic deb_ok;
    logic en_ok;
    logic fs_ok;
    deb_ok  = !dv || (CMP_W'(de) >= CMP_W'(deb_ms));
    en_ok   = mouse ? en[ptt_pkg::EN_MOUSE] : en[ptt_pkg::EN_KB];
    fs_ok   = mouse ? en[ptt_pkg::EN_MOUSE_FS] : en[ptt_pkg::EN_KB_FS];
    allowed = deb_ok && en_ok && (fs_ok || !fs);
  endfunction

  always_comb begin
    logic       cur_lvl;
    logic       was_held;
    logic       hold_mode;
    logic       done;
    logic       kb_ok;
    logic [2:0] lv;

    ctl_nxt    = ctl;
    deb_e_nxt  = deb_e;
    tap_e_nxt  = tap_e;
    hold_c_nxt = hold_c;
    emit       = 1'b0;
    ev         = ptt_pkg::EV_PRESSED;
    done       = 1'b0;
    kb_ok      = 1'b0;
    hold_mode  = (cfg.keyboard_mode == ptt_pkg::KB_HOLD);
    lv         = ctl.levels;
    was_held   = mouse_held(ctl.levels, cfg.mouse_button);

    case (item.input_id)
      ptt_pkg::ID_KEY:  cur_lvl = ctl.levels[0];
      ptt_pkg::ID_BTN1: cur_lvl = ctl.levels[1];
      default:          cur_lvl = ctl.levels[2];
    endcase

    case (item.req_type)
      ptt_pkg::REQ_LEVEL: begin
        if (item.input_id != 2'd3 && cur_lvl != item.down) begin
          case (item.input_id)
            ptt_pkg::ID_KEY:  lv[0] = item.down;
            ptt_pkg::ID_BTN1: lv[1] = item.down;
            default:          lv[2] = item.down;
          endcase
          ctl_nxt.levels = lv;
          if (item.input_id == ptt_pkg::ID_KEY) begin
            if (!item.down) ctl_nxt.confirm_active = 1'b0;
            if (ctl.owner == ptt_pkg::OWN_KEY && hold_mode && !item.down) begin
              ctl_nxt.owner          = ptt_pkg::OWN_NONE;
              ctl_nxt.debounce_valid = 1'b1;
              deb_e_nxt              = '0;
              ctl_nxt.tap_valid      = 1'b0;
              emit                   = 1'b1;
              ev                     = ptt_pkg::EV_RELEASED;
            end else if (item.down &&
                         ((ctl.owner == ptt_pkg::OWN_KEY && !hold_mode) ||
                          (ctl.owner == ptt_pkg::OWN_NONE && item.modifiers_match &&
                           allowed(1'b0, item.fullscreen, ctl.debounce_valid, deb_e,
                                   cfg.enable_flags, cfg.debounce_ms)))) begin
              ctl_nxt.confirm_active = 1'b1;
              ctl_nxt.confirm_count  = '0;
            end
          end else if (!mouse_held(lv, cfg.mouse_button)) begin
            ctl_nxt.hold_active = 1'b0;
            if (ctl.owner == ptt_pkg::OWN_MOUSE) begin
              ctl_nxt.owner          = ptt_pkg::OWN_NONE;
              ctl_nxt.debounce_valid = 1'b1;
              deb_e_nxt              = '0;
              emit                   = 1'b1;
              ev                     = ptt_pkg::EV_RELEASED;
            end
          end else if (!was_held && ctl.owner == ptt_pkg::OWN_NONE &&
                       allowed(1'b1, item.fullscreen, ctl.debounce_valid, deb_e,
                               cfg.enable_flags, cfg.debounce_ms)) begin
            ctl_nxt.hold_active = 1'b1;
            hold_c_nxt          = '0;
          end
        end
      end
      ptt_pkg::REQ_ESCAPE: begin
        ctl_nxt.confirm_active = 1'b0;
        ctl_nxt.tap_valid      = 1'b0;
        if (ctl.owner == ptt_pkg::OWN_KEY) begin
          ctl_nxt.owner          = ptt_pkg::OWN_NONE;
          ctl_nxt.debounce_valid = 1'b1;
          deb_e_nxt              = '0;
          emit                   = 1'b1;
          ev                     = ptt_pkg::EV_CANCELLED;
        end
      end
      ptt_pkg::REQ_TICK: begin
        if (ctl.debounce_valid) deb_e_nxt = sat_inc(deb_e);
        if (ctl.tap_valid) tap_e_nxt = sat_inc(tap_e);
        if (ctl.confirm_active) begin
          ctl_nxt.confirm_count = CNT_W'(ctl.confirm_count + 1'b1);
          if (ctl_nxt.confirm_count >= CNT_W'(CONFIRM_TICKS)) begin
            ctl_nxt.confirm_active = 1'b0;
            kb_ok = allowed(1'b0, item.fullscreen, ctl.debounce_valid, deb_e_nxt,
                            cfg.enable_flags, cfg.debounce_ms) && item.modifiers_match;
            if (ctl.levels[0]) begin
              if (ctl.owner == ptt_pkg::OWN_KEY && !hold_mode) begin
                ctl_nxt.owner          = ptt_pkg::OWN_NONE;
                ctl_nxt.debounce_valid = 1'b1;
                deb_e_nxt              = '0;
                ctl_nxt.tap_valid      = 1'b0;
                emit                   = 1'b1;
                ev                     = ptt_pkg::EV_RELEASED;
                done                   = 1'b1;
              end else if (ctl.owner == ptt_pkg::OWN_NONE && kb_ok) begin
                if (cfg.keyboard_mode == ptt_pkg::KB_DOUBLE_TAP &&
                    (!ctl.tap_valid ||
                     CMP_W'(tap_e_nxt) > CMP_W'(cfg.double_tap_window_ms))) begin
                  ctl_nxt.tap_valid = 1'b1;
                  tap_e_nxt         = '0;
                end else begin
                  if (cfg.keyboard_mode == ptt_pkg::KB_DOUBLE_TAP)
                    ctl_nxt.tap_valid = 1'b0;
                  ctl_nxt.owner       = ptt_pkg::OWN_KEY;
                  ctl_nxt.hold_active = 1'b0;
                  emit                = 1'b1;
                  ev                  = ptt_pkg::EV_PRESSED;
                  done                = 1'b1;
                end
              end
            end
          end
        end
        if (!done && ctl.hold_active) begin
          hold_c_nxt = sat_inc(hold_c);
          if (CMP_W'(hold_c_nxt) >= CMP_W'(cfg.hold_delay_ms)) begin
            ctl_nxt.hold_active = 1'b0;
            if (ctl.owner == ptt_pkg::OWN_NONE && mouse_held(ctl.levels, cfg.mouse_button) &&
                allowed(1'b1, item.fullscreen, ctl_nxt.debounce_valid, deb_e_nxt,
                        cfg.enable_flags, cfg.debounce_ms)) begin
              ctl_nxt.owner = ptt_pkg::OWN_MOUSE;
              emit          = 1'b1;
              ev            = ptt_pkg::EV_PRESSED;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/push_to_talk_trigger_fsm.sv =====
// Top level of the push-to-talk trigger arbiter: registers, handshakes, config port.
//
//   channel | direction | transfer condition              | payload
//   in_     | input     | in_valid & !in_stall            | req_type, input_id, down, mods, fs
//   out_    | output    | out_valid & !out_stall          | event_res, owner
//   cfg_    | APB write | psel & penable & pwrite & pready | paddr, pwdata
//
// One item per cycle while the output is not stalled: an item is registered on
// transfer, evaluated by a single pass of the step logic once the output can
// accept, and any event it emits is registered in the output register.
// Synchronous active-low reset sets config defaults and clears control state and timers.
// A stalled output holds its result; a pending item then stays put and in_stall rises.
module push_to_talk_trigger_fsm #(
  parameter int CONFIRM_TICKS = 10,
  parameter int TIME_BITS     = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [1:0]                 in_input_id,
  input  logic                       in_down,
  input  logic                       in_modifiers_match,
  input  logic                       in_fullscreen,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_event_res,
  output logic [1:0]                 out_owner,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ptt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  ptt_pkg::cfg_t        cfg_r;
  ptt_pkg::item_t       item_r;
  ptt_pkg::ctl_t        ctl_r, ctl_nxt;
  logic                 s1_valid_r;
  logic [TIME_BITS-1:0] deb_e_r, tap_e_r, hold_c_r;
  logic [TIME_BITS-1:0] deb_e_nxt, tap_e_nxt, hold_c_nxt;
  logic                 emit;
  ptt_pkg::event_t      ev;
  logic                 out_valid_r;
  logic [1:0]           out_event_r, out_owner_r;
  logic                 s1_go, in_xfer, step, cfg_wr;
  logic [2:0]           cfg_idx;

  assign s1_go    = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;
  assign step     = s1_valid_r && s1_go;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  ptt_step #(
    .CONFIRM_TICKS(CONFIRM_TICKS),
    .TIME_BITS    (TIME_BITS)
  ) u_step (
    .cfg       (cfg_r),
    .item      (item_r),
    .ctl       (ctl_r),
    .deb_e     (deb_e_r),
    .tap_e     (tap_e_r),
    .hold_c    (hold_c_r),
    .ctl_nxt   (ctl_nxt),
    .deb_e_nxt (deb_e_nxt),
    .tap_e_nxt (tap_e_nxt),
    .hold_c_nxt(hold_c_nxt),
    .emit      (emit),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.keyboard_mode        <= ptt_pkg::RST_KB_MODE;
      cfg_r.mouse_button         <= ptt_pkg::RST_MOUSE_BTN;
      cfg_r.enable_flags         <= ptt_pkg::RST_ENABLES;
      cfg_r.debounce_ms          <= ptt_pkg::RST_DEBOUNCE;
      cfg_r.double_tap_window_ms <= ptt_pkg::RST_TAP_WINDOW;
      cfg_r.hold_delay_ms        <= ptt_pkg::RST_HOLD_DELAY;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ptt_pkg::REG_KB_MODE:    cfg_r.keyboard_mode        <= cfg_pwdata[1:0];
        ptt_pkg::REG_MOUSE_BTN:  cfg_r.mouse_button         <= cfg_pwdata[1:0];
        ptt_pkg::REG_ENABLES:    cfg_r.enable_flags         <= cfg_pwdata[3:0];
        ptt_pkg::REG_DEBOUNCE:   cfg_r.debounce_ms          <= cfg_pwdata[15:0];
        ptt_pkg::REG_TAP_WINDOW: cfg_r.double_tap_window_ms <= cfg_pwdata[15:0];
        ptt_pkg::REG_HOLD_DELAY: cfg_r.hold_delay_ms        <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ptt_pkg::REG_KB_MODE:    cfg_prdata = 32'(cfg_r.keyboard_mode);
      ptt_pkg::REG_MOUSE_BTN:  cfg_prdata = 32'(cfg_r.mouse_button);
      ptt_pkg::REG_ENABLES:    cfg_prdata = 32'(cfg_r.enable_flags);
      ptt_pkg::REG_DEBOUNCE:   cfg_prdata = 32'(cfg_r.debounce_ms);
      ptt_pkg::REG_TAP_WINDOW: cfg_prdata = 32'(cfg_r.double_tap_window_ms);
      ptt_pkg::REG_HOLD_DELAY: cfg_prdata = 32'(cfg_r.hold_delay_ms);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer || (s1_valid_r && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.req_type        <= in_req_type;
      item_r.input_id        <= in_input_id;
      item_r.down            <= in_down;
      item_r.modifiers_match <= in_modifiers_match;
      item_r.fullscreen      <= in_fullscreen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.owner          <= ptt_pkg::OWN_NONE;
      ctl_r.levels         <= '0;
      ctl_r.confirm_active <= 1'b0;
      ctl_r.confirm_count  <= '0;
      ctl_r.hold_active    <= 1'b0;
      ctl_r.debounce_valid <= 1'b0;
      ctl_r.tap_valid      <= 1'b0;
      deb_e_r              <= '0;
      tap_e_r              <= '0;
      hold_c_r             <= '0;
    end else if (step) begin
      ctl_r    <= ctl_nxt;
      deb_e_r  <= deb_e_nxt;
      tap_e_r  <= tap_e_nxt;
      hold_c_r <= hold_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_event_r <= ev;
      out_owner_r <= ctl_nxt.owner;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;
  assign out_owner     = out_owner_r;

endmodule
